@@ hw/rtl/arm_thumb_branch_execute_macros.svh @@
// Assertion macros for the ARM/THUMB branch execute block.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef ARM_THUMB_BRANCH_EXECUTE_MACROS_SVH
`define ARM_THUMB_BRANCH_EXECUTE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ABT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("branch execute check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define ABT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("branch execute check failed");

`endif

@@ hw/rtl/abt_pkg.sv @@
// Shared types and constants for the ARM/THUMB branch execute block.
// No dependencies; used by the decoder, the top level, the result checker and the testbench.
`timescale 1ns / 1ps

package abt_pkg;

    localparam int KIND_W  = 4;
    localparam int WORD_W  = 32;
    localparam int COND_W  = 4;
    localparam int FLAGS_W = 4;
    localparam int CYC_W   = 2;

    // Link offsets relative to the PC as read by the instruction.
    localparam logic [WORD_W-1:0] LR_OFF_ARM   = 32'hFFFF_FFFC;
    localparam logic [WORD_W-1:0] LR_OFF_THUMB = 32'hFFFF_FFFF;

    localparam logic [CYC_W-1:0] CYC_TAKEN     = 2'd3;
    localparam logic [CYC_W-1:0] CYC_NOT_TAKEN = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARM_BX      = 4'd0,
        KIND_ARM_BLX_REG = 4'd1,
        KIND_ARM_B       = 4'd2,
        KIND_ARM_BL      = 4'd3,
        KIND_ARM_BLX_IMM = 4'd4,
        KIND_T_BX        = 4'd5,
        KIND_T_BLX       = 4'd6,
        KIND_T_BCOND     = 4'd7,
        KIND_T_B         = 4'd8,
        KIND_T_BL_HI     = 4'd9,
        KIND_T_BL_LO     = 4'd10,
        KIND_T_BLX_LO    = 4'd11
    } kind_t;

    typedef enum logic [COND_W-1:0] {
        COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
        COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
        COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
        COND_GT = 4'd12, COND_LE = 4'd13
    } cond_t;

    // Decoded branch: write enables, THUMB bit and the operands of both adders.
    typedef struct packed {
        logic              pc_write;
        logic              lr_write;
        logic              thumb;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] lr_off;
    } dec_t;

endpackage

@@ hw/rtl/abt_decode.sv @@
// Branch decoder: turns one request into write enables, THUMB bit and adder operands.
// Depends on abt_pkg.
`timescale 1ns / 1ps

module abt_decode (
    input  logic [abt_pkg::KIND_W-1:0]  req_type,
    input  logic [abt_pkg::WORD_W-1:0]  opcode,
    input  logic [abt_pkg::COND_W-1:0]  condition,
    input  logic [abt_pkg::WORD_W-1:0]  reg_value,
    input  logic [abt_pkg::WORD_W-1:0]  pc_value,
    input  logic [abt_pkg::WORD_W-1:0]  lr_value,
    input  logic [abt_pkg::FLAGS_W-1:0] flags,
    input  logic                        thumb_in,
    input  logic                        older_core,
    output abt_pkg::dec_t               dec
);
    import abt_pkg::*;

    logic fl_n, fl_z, fl_c, fl_v;
    logic cond_ok;

    assign fl_n = flags[3];
    assign fl_z = flags[2];
    assign fl_c = flags[1];
    assign fl_v = flags[0];

    // Condition check for the THUMB conditional branch.
    always_comb begin
        case (cond_t'(condition))
            COND_EQ: cond_ok = fl_z;
            COND_NE: cond_ok = !fl_z;
            COND_CS: cond_ok = fl_c;
            COND_CC: cond_ok = !fl_c;
            COND_MI: cond_ok = fl_n;
            COND_PL: cond_ok = !fl_n;
            COND_VS: cond_ok = fl_v;
            COND_VC: cond_ok = !fl_v;
            COND_HI: cond_ok = fl_c && !fl_z;
            COND_LS: cond_ok = !fl_c || fl_z;
            COND_GE: cond_ok = (fl_n == fl_v);
            COND_LT: cond_ok = (fl_n != fl_v);
            COND_GT: cond_ok = !fl_z && (fl_n == fl_v);
            COND_LE: cond_ok = fl_z || (fl_n != fl_v);
            default: cond_ok = 1'b0;
        endcase
    end

    // Kind decode. The new PC is base + offset, the new LR is pc + lr_off.
    always_comb begin
        dec          = '0;
        dec.thumb    = thumb_in;
        dec.pc       = pc_value;
        unique case (kind_t'(req_type))
            KIND_ARM_BX: begin
                dec.thumb    = thumb_in | reg_value[0];
                dec.base     = reg_value;
                dec.pc_write = 1'b1;
            end
            KIND_ARM_BLX_REG: begin
                if (!older_core) begin
                    dec.thumb    = thumb_in | reg_value[0];
                    dec.base     = reg_value;
                    dec.pc_write = 1'b1;
                    dec.lr_off   = LR_OFF_ARM;
                    dec.lr_write = 1'b1;
                end
            end
            KIND_ARM_B: begin
                dec.base     = pc_value;
                dec.offset   = {{6{opcode[23]}}, opcode[23:0], 2'b00};
                dec.pc_write = 1'b1;
            end
            KIND_ARM_BL: begin
                dec.base     = pc_value;
                dec.offset   = {{6{opcode[23]}}, opcode[23:0], 2'b00};
                dec.pc_write = 1'b1;
                dec.lr_off   = LR_OFF_ARM;
                dec.lr_write = 1'b1;
            end
            KIND_ARM_BLX_IMM: begin
                // The H bit supplies bit 1 of the target offset.
                if (!older_core) begin
                    dec.thumb    = 1'b1;
                    dec.base     = pc_value;
                    dec.offset   = {{6{opcode[23]}}, opcode[23:0], opcode[24], 1'b0};
                    dec.pc_write = 1'b1;
                    dec.lr_off   = LR_OFF_ARM;
                    dec.lr_write = 1'b1;
                end
            end
            KIND_T_BX: begin
                dec.thumb    = thumb_in & reg_value[0];
                dec.base     = reg_value;
                dec.pc_write = 1'b1;
            end
            KIND_T_BLX: begin
                if (!older_core) begin
                    dec.thumb    = thumb_in & reg_value[0];
                    dec.base     = reg_value;
                    dec.pc_write = 1'b1;
                    dec.lr_off   = LR_OFF_THUMB;
                    dec.lr_write = 1'b1;
                end
            end
            KIND_T_BCOND: begin
                if (cond_ok) begin
                    dec.base     = pc_value;
                    dec.offset   = {{23{opcode[7]}}, opcode[7:0], 1'b0};
                    dec.pc_write = 1'b1;
                end
            end
            KIND_T_B: begin
                dec.base     = pc_value;
                dec.offset   = {{20{opcode[10]}}, opcode[10:0], 1'b0};
                dec.pc_write = 1'b1;
            end
            KIND_T_BL_HI: begin
                // First half of the long branch only writes the PC plus the upper offset to LR.
                dec.lr_off   = {{9{opcode[10]}}, opcode[10:0], 12'h000};
                dec.lr_write = 1'b1;
            end
            KIND_T_BL_LO: begin
                dec.base     = lr_value;
                dec.offset   = {20'h00000, opcode[10:0], 1'b0};
                dec.pc_write = 1'b1;
                dec.lr_off   = LR_OFF_THUMB;
                dec.lr_write = 1'b1;
            end
            KIND_T_BLX_LO: begin
                if (!older_core) begin
                    dec.thumb    = 1'b0;
                    dec.base     = lr_value;
                    dec.offset   = {20'h00000, opcode[10:0], 1'b0};
                    dec.pc_write = 1'b1;
                    dec.lr_off   = LR_OFF_THUMB;
                    dec.lr_write = 1'b1;
                end
            end
            default: begin
                dec.thumb = thumb_in;
            end
        endcase
    end

endmodule

@@ hw/rtl/arm_thumb_branch_execute.sv @@
// Top level of the ARM/THUMB branch execute block: three-stage pipeline.
// Depends on abt_pkg and abt_decode.
`timescale 1ns / 1ps

// Usage:
// A request enters on the s_ channel (valid/ready) carrying one branch
// instruction with its operands; one result leaves on the m_ channel with
// the new PC, new LR, their write flags, the THUMB bit and the cycle count.
// The cfg_ channel writes the older-core mode bit; write it only while no
// request is in flight. cfg_ready is always high.
// The request passes three register stages: decode, then the target and
// link adders, then the output register, whose valid bit drives m_valid.
// Throughput is one request per cycle while m_ready does not stall.
// Each stage holds its request while the next one is full, so a stall on
// m_ready backs up stage by stage and s_ready drops only when all three
// stages are occupied; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties all stages and clears the mode
// bit to the newer core.

module arm_thumb_branch_execute (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [abt_pkg::KIND_W-1:0]  s_req_type,
    input  logic [abt_pkg::WORD_W-1:0]  s_opcode,
    input  logic [abt_pkg::COND_W-1:0]  s_condition,
    input  logic [abt_pkg::WORD_W-1:0]  s_reg_value,
    input  logic [abt_pkg::WORD_W-1:0]  s_pc_value,
    input  logic [abt_pkg::WORD_W-1:0]  s_lr_value,
    input  logic [abt_pkg::FLAGS_W-1:0] s_flags,
    input  logic                        s_thumb_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [abt_pkg::WORD_W-1:0]  m_new_pc,
    output logic                        m_pc_write,
    output logic [abt_pkg::WORD_W-1:0]  m_new_lr,
    output logic                        m_lr_write,
    output logic                        m_thumb_out,
    output logic [abt_pkg::CYC_W-1:0]   m_cycle_count
);
    import abt_pkg::*;

    logic              older_core_reg;
    dec_t              dec;
    dec_t              dec_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [WORD_W-1:0] npc_reg, nlr_reg;
    logic              pw2_reg, lw2_reg, t2_reg;
    logic [WORD_W-1:0] out_pc_reg, out_lr_reg;
    logic              out_pw_reg, out_lw_reg, out_t_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_core_reg <= 1'b0;
        end else if (cfg_valid) begin
            older_core_reg <= cfg_data;
        end
    end

    // Per-stage flow control: a stage takes a request when it is empty or drains.
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: decode the request.
    abt_decode u_decode (
        .req_type   (s_req_type),
        .opcode     (s_opcode),
        .condition  (s_condition),
        .reg_value  (s_reg_value),
        .pc_value   (s_pc_value),
        .lr_value   (s_lr_value),
        .flags      (s_flags),
        .thumb_in   (s_thumb_in),
        .older_core (older_core_reg),
        .dec        (dec)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            dec_reg <= dec;
        end
    end

    // Stage 2: target and link adders.
    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            npc_reg <= dec_reg.base + dec_reg.offset;
            nlr_reg <= dec_reg.pc + dec_reg.lr_off;
            pw2_reg <= dec_reg.pc_write;
            lw2_reg <= dec_reg.lr_write;
            t2_reg  <= dec_reg.thumb;
        end
    end

    // Stage 3: output register; unwritten results read as zero.
    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            out_pc_reg <= pw2_reg ? npc_reg : '0;
            out_lr_reg <= lw2_reg ? nlr_reg : '0;
            out_pw_reg <= pw2_reg;
            out_lw_reg <= lw2_reg;
            out_t_reg  <= t2_reg;
        end
    end

    assign m_valid       = v3_reg;
    assign m_new_pc      = out_pc_reg;
    assign m_pc_write    = out_pw_reg;
    assign m_new_lr      = out_lr_reg;
    assign m_lr_write    = out_lw_reg;
    assign m_thumb_out   = out_t_reg;
    assign m_cycle_count = out_pw_reg ? CYC_TAKEN : CYC_NOT_TAKEN;

endmodule

@@ hw/rtl/abt_checker.sv @@
// Port checker for the ARM/THUMB branch execute block, bound to the top level.
// Depends on arm_thumb_branch_execute_macros.svh and arm_thumb_branch_execute.
`timescale 1ns / 1ps
`include "arm_thumb_branch_execute_macros.svh"

module abt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_new_pc,
    input logic        m_pc_write,
    input logic [31:0] m_new_lr,
    input logic        m_lr_write,
    input logic [1:0]  m_cycle_count
);

    // A stalled result stays offered with the same target.
    `ABT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_new_pc) && $stable(m_new_lr))

    // A branch that is not taken reports the not-taken cycle count and carries no target.
    `ABT_ASSERT_NOW(a_not_taken, m_valid && !m_pc_write, m_new_pc == 32'h0 && m_cycle_count == 2'd1)

    // A taken branch reports the taken cycle count.
    `ABT_ASSERT_NOW(a_taken, m_valid && m_pc_write, m_cycle_count == 2'd3)

    // No link write means a zero link value.
    `ABT_ASSERT_NOW(a_no_link, m_valid && !m_lr_write, m_new_lr == 32'h0)

endmodule

bind arm_thumb_branch_execute abt_checker u_abt_checker (.*);

@@ verif/branch_result_checker.sv @@
// Checker for the ARM/THUMB branch execute block: predicts and compares results.
// Depends on abt_pkg. Watches the cfg_, s_ and m_ channels and reports failures.
`timescale 1ns / 1ps

module branch_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [abt_pkg::KIND_W-1:0]  s_req_type,
    input  logic [abt_pkg::WORD_W-1:0]  s_opcode,
    input  logic [abt_pkg::COND_W-1:0]  s_condition,
    input  logic [abt_pkg::WORD_W-1:0]  s_reg_value,
    input  logic [abt_pkg::WORD_W-1:0]  s_pc_value,
    input  logic [abt_pkg::WORD_W-1:0]  s_lr_value,
    input  logic [abt_pkg::FLAGS_W-1:0] s_flags,
    input  logic                        s_thumb_in,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [abt_pkg::WORD_W-1:0]  m_new_pc,
    input  logic                        m_pc_write,
    input  logic [abt_pkg::WORD_W-1:0]  m_new_lr,
    input  logic                        m_lr_write,
    input  logic                        m_thumb_out,
    input  logic [abt_pkg::CYC_W-1:0]   m_cycle_count,
    output int                          outstanding,
    output int                          mismatches
);
    import abt_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] new_pc;
        logic              pc_write;
        logic [WORD_W-1:0] new_lr;
        logic              lr_write;
        logic              thumb;
        logic [CYC_W-1:0]  cycles;
    } outcome_t;

    outcome_t expected_outcomes[$];
    logic     older_core = 1'b0;
    int       errors = 0;

    // Evaluates a THUMB condition against the N Z C V flags.
    function automatic logic cond_holds(logic [COND_W-1:0] cond, logic [FLAGS_W-1:0] fl);
        logic n, z, c, v;
        n = fl[3];
        z = fl[2];
        c = fl[1];
        v = fl[0];
        case (cond)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            default: return 1'b0;
        endcase
    endfunction

    // Computes the outcome of one branch request under the given core mode.
    function automatic outcome_t branch_outcome(
        logic [KIND_W-1:0]  kind,
        logic [WORD_W-1:0]  op,
        logic [COND_W-1:0]  cond,
        logic [WORD_W-1:0]  rv,
        logic [WORD_W-1:0]  pc,
        logic [WORD_W-1:0]  lr,
        logic [FLAGS_W-1:0] fl,
        logic               t,
        logic               older
    );
        outcome_t r;
        r = '0;
        r.thumb = t;
        case (kind)
            KIND_ARM_BX: begin
                r.thumb = t | rv[0];
                r.new_pc = rv;
                r.pc_write = 1'b1;
            end
            KIND_ARM_BLX_REG: if (!older) begin
                r.thumb = t | rv[0];
                r.new_lr = pc - 32'd4;
                r.lr_write = 1'b1;
                r.new_pc = rv;
                r.pc_write = 1'b1;
            end
            KIND_ARM_B: begin
                r.new_pc = pc + {{6{op[23]}}, op[23:0], 2'b00};
                r.pc_write = 1'b1;
            end
            KIND_ARM_BL: begin
                r.new_lr = pc - 32'd4;
                r.lr_write = 1'b1;
                r.new_pc = pc + {{6{op[23]}}, op[23:0], 2'b00};
                r.pc_write = 1'b1;
            end
            KIND_ARM_BLX_IMM: if (!older) begin
                // The H bit supplies the halfword offset of the THUMB target.
                r.thumb = 1'b1;
                r.new_lr = pc - 32'd4;
                r.lr_write = 1'b1;
                r.new_pc = pc + {{6{op[23]}}, op[23:0], op[24], 1'b0};
                r.pc_write = 1'b1;
            end
            KIND_T_BX: begin
                r.thumb = t & rv[0];
                r.new_pc = rv;
                r.pc_write = 1'b1;
            end
            KIND_T_BLX: if (!older) begin
                r.thumb = t & rv[0];
                r.new_lr = pc - 32'd1;
                r.lr_write = 1'b1;
                r.new_pc = rv;
                r.pc_write = 1'b1;
            end
            KIND_T_BCOND: if (cond_holds(cond, fl)) begin
                r.new_pc = pc + {{23{op[7]}}, op[7:0], 1'b0};
                r.pc_write = 1'b1;
            end
            KIND_T_B: begin
                r.new_pc = pc + {{20{op[10]}}, op[10:0], 1'b0};
                r.pc_write = 1'b1;
            end
            KIND_T_BL_HI: begin
                // The first half of a long branch only loads the PC plus the upper offset into LR.
                r.new_lr = pc + {{9{op[10]}}, op[10:0], 12'b0};
                r.lr_write = 1'b1;
            end
            KIND_T_BL_LO: begin
                r.new_pc = lr + {20'b0, op[10:0], 1'b0};
                r.pc_write = 1'b1;
                r.new_lr = pc - 32'd1;
                r.lr_write = 1'b1;
            end
            KIND_T_BLX_LO: if (!older) begin
                r.thumb = 1'b0;
                r.new_pc = lr + {20'b0, op[10:0], 1'b0};
                r.pc_write = 1'b1;
                r.new_lr = pc - 32'd1;
                r.lr_write = 1'b1;
            end
            default: ;
        endcase
        r.cycles = r.pc_write ? CYC_TAKEN : CYC_NOT_TAKEN;
        return r;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Track the mode bit, queue a prediction per request and compare each result.
    always @(posedge aclk) begin : monitor
        outcome_t want;
        if (!aresetn) begin
            older_core = 1'b0;
            expected_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("new_pc", want.new_pc, m_new_pc);
                    check_field("pc_write", WORD_W'(want.pc_write), WORD_W'(m_pc_write));
                    check_field("new_lr", want.new_lr, m_new_lr);
                    check_field("lr_write", WORD_W'(want.lr_write), WORD_W'(m_lr_write));
                    check_field("thumb_out", WORD_W'(want.thumb), WORD_W'(m_thumb_out));
                    check_field("cycle_count", WORD_W'(want.cycles),
                                WORD_W'(m_cycle_count));
                end
            end
            // A request taken at the same edge as a mode write still sees the old mode.
            if (s_valid && s_ready)
                expected_outcomes.push_back(branch_outcome(s_req_type, s_opcode,
                    s_condition, s_reg_value, s_pc_value, s_lr_value, s_flags,
                    s_thumb_in, older_core));
            if (cfg_valid && cfg_ready)
                older_core = cfg_data;
        end
        outstanding <= expected_outcomes.size();
        mismatches <= errors;
    end

endmodule

@@ verif/arm_thumb_branch_execute_tb.sv @@
// Testbench top for the ARM/THUMB branch execute block: clock, reset and stimulus.
// Depends on abt_pkg, arm_thumb_branch_execute and branch_result_checker.
`timescale 1ns / 1ps

module arm_thumb_branch_execute_tb;
    import abt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = KIND_W'(KIND_T_BLX_LO + 1);
    localparam logic [KIND_W-1:0] KIND_LAST         = '1;
    localparam logic [COND_W-1:0] COND_NEVER_FIRST  = COND_W'(COND_LE + 1);
    localparam logic [COND_W-1:0] COND_LAST         = '1;
    localparam int PHASES          = 6;
    localparam int PHASE_REQUESTS  = 185;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_req_type = '0;
    logic [WORD_W-1:0]    s_opcode = '0;
    logic [COND_W-1:0]    s_condition = '0;
    logic [WORD_W-1:0]    s_reg_value = '0;
    logic [WORD_W-1:0]    s_pc_value = '0;
    logic [WORD_W-1:0]    s_lr_value = '0;
    logic [FLAGS_W-1:0]   s_flags = '0;
    logic                 s_thumb_in = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic [WORD_W-1:0]    m_new_pc;
    logic                 m_pc_write;
    logic [WORD_W-1:0]    m_new_lr;
    logic                 m_lr_write;
    logic                 m_thumb_out;
    logic [CYC_W-1:0]     m_cycle_count;
    int                   outstanding;
    int                   mismatches;

    logic                 quiet = 1'b0;
    logic                 rx_stalls_on = 1'b1;
    int                   stall_left = 0;
    int                   sent = 0;
    int                   writes = 0;

    always #5 aclk = ~aclk;

    arm_thumb_branch_execute DUT (.*);

    branch_result_checker checker_i (.*);

    // Result side: random stall bursts on m_ready, with calm stretches in between.
    always @(posedge aclk) begin
        if ($urandom_range(0, 249) == 0)
            rx_stalls_on = !rx_stalls_on;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && rx_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Presents one request and holds it until it is accepted; valid stays high.
    task automatic send(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] op,
                        logic [COND_W-1:0] cond, logic [WORD_W-1:0] rv,
                        logic [WORD_W-1:0] pc, logic [WORD_W-1:0] lr,
                        logic [FLAGS_W-1:0] fl, logic t);
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_opcode <= op;
        s_condition <= cond;
        s_reg_value <= rv;
        s_pc_value <= pc;
        s_lr_value <= lr;
        s_flags <= fl;
        s_thumb_in <= t;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic pause(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_mode(logic older);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= older;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        writes++;
    endtask

    // Word values lean toward the extremes now and then.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(WORD_W-1){1'b0}}};
            3:       return {1'b0, {(WORD_W-1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        logic [KIND_W-1:0] kind;
        logic [COND_W-1:0] cond;
        if ($urandom_range(0, 19) == 0)
            kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_LAST));
        else
            kind = KIND_W'($urandom_range(KIND_ARM_BX, KIND_T_BLX_LO));
        if ($urandom_range(0, 9) == 0)
            cond = COND_W'($urandom_range(COND_NEVER_FIRST, COND_LAST));
        else
            cond = COND_W'($urandom_range(COND_EQ, COND_LE));
        send(kind, pick_word(), cond, pick_word(), pick_word(), pick_word(),
             FLAGS_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        bit gaps_on;
        bit last_stretch;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the newer core (mode bit cleared by reset).
        send(KIND_ARM_BX, '0, COND_EQ, '1, 32'h0000_1000, '0, 4'h0, 1'b0);
        send(KIND_ARM_BX, '1, COND_EQ, '0, '1, '1, 4'hF, 1'b1);
        send(KIND_ARM_BLX_REG, '0, COND_EQ, 32'h0000_0001, '0, '0, 4'h0, 1'b0);
        send(KIND_ARM_B, 32'h0080_0000, COND_EQ, '0, '0, '0, 4'h0, 1'b0);
        send(KIND_ARM_B, 32'h007F_FFFF, COND_EQ, '0, '1, '0, 4'h0, 1'b1);
        send(KIND_ARM_BL, '1, COND_EQ, '0, 32'h0000_0002, '0, 4'h0, 1'b0);
        send(KIND_ARM_BLX_IMM, 32'h01FF_FFFF, COND_EQ, '0, 32'h8000_0000, '0, 4'h0, 1'b0);
        send(KIND_ARM_BLX_IMM, '0, COND_EQ, '0, '0, '0, 4'h0, 1'b1);
        send(KIND_T_BX, '0, COND_EQ, '0, 32'h0000_4000, '0, 4'h0, 1'b1);
        send(KIND_T_BX, '1, COND_EQ, '1, 32'h0000_4000, '0, 4'h0, 1'b1);
        send(KIND_T_BLX, '0, COND_EQ, 32'h0000_0001, '0, '0, 4'h0, 1'b0);
        send(KIND_T_BCOND, 32'h0000_0080, COND_EQ, '0, '0, '0, 4'h4, 1'b1);
        send(KIND_T_BCOND, 32'hFFFF_007F, COND_LE, '0, '1, '0, 4'h1, 1'b1);
        send(KIND_T_BCOND, '1, COND_NEVER_FIRST, '0, '1, '0, 4'hF, 1'b1);
        send(KIND_T_BCOND, '1, COND_LAST, '0, '1, '0, 4'hF, 1'b1);
        send(KIND_T_B, 32'h0000_0400, COND_EQ, '0, '0, '0, 4'h0, 1'b1);
        send(KIND_T_B, 32'h0000_03FF, COND_EQ, '0, '1, '0, 4'h0, 1'b1);
        send(KIND_T_BL_HI, '1, COND_EQ, '0, '0, '0, 4'h0, 1'b1);
        send(KIND_T_BL_LO, 32'h0000_07FF, COND_EQ, '0, '0, '1, 4'h0, 1'b1);
        send(KIND_T_BLX_LO, '1, COND_EQ, '0, '1, '1, 4'h0, 1'b1);
        send(KIND_LAST, '1, COND_LAST, '1, '1, '1, 4'hF, 1'b1);

        // Directed requests on the older core: the exchange forms do nothing.
        write_mode(1'b1);
        send(KIND_ARM_BLX_REG, '1, COND_EQ, '1, '1, '1, 4'hF, 1'b0);
        send(KIND_ARM_BLX_IMM, '1, COND_EQ, '1, '1, '1, 4'hF, 1'b0);
        send(KIND_T_BLX, '1, COND_EQ, '1, '1, '1, 4'hF, 1'b1);
        send(KIND_T_BLX_LO, '1, COND_EQ, '1, '1, '1, 4'hF, 1'b1);

        // Random phases alternating the core mode; the last phase runs without idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_mode(ph[0]);
            gaps_on = $urandom_range(0, 3) != 0;
            last_stretch = (ph == PHASES - 1);
            if (last_stretch)
                quiet <= 1'b1;
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                if (ph == 2 && i == PHASE_REQUESTS / 2)
                    drain();
                else if (!last_stretch && gaps_on && $urandom_range(0, 5) == 0)
                    pause($urandom_range(1, 14));
                random_request();
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        $display("Run summary: %0d branch requests, all kinds and condition codes, %0d mode writes.",
                 sent, writes);
        $display("Both core modes were covered with random stalls on each side.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ arm_thumb_branch_execute.f @@
+incdir+hw/rtl
hw/rtl/abt_pkg.sv
hw/rtl/abt_decode.sv
hw/rtl/arm_thumb_branch_execute.sv
hw/rtl/abt_checker.sv
verif/branch_result_checker.sv
verif/arm_thumb_branch_execute_tb.sv
